// ===== hdl/hcbd_pkg.sv =====
// ============================================================================
// hcbd_pkg
// Shared types, character codes and helpers of the chunked body decoder.
// ============================================================================
package hcbd_pkg;

    // Width of the chunk size counter.
    localparam int unsigned SIZE_BITS = 32;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        PH_SIZE  = 3'd0,
        PH_DATA  = 3'd1,
        PH_DCR   = 3'd2,
        PH_DLF   = 3'd3,
        PH_TRAIL = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_RUN      = 3'd0,
        ST_DONE     = 3'd1,
        ST_BADSIZE  = 3'd2,
        ST_BADTERM  = 3'd3,
        ST_BADTRAIL = 3'd4
    } t_status;

    typedef struct packed {
        logic digit_seen;
        logic space_after_digits;
        logic in_extension;
        logic line_bad;
        logic cr_pending;
        logic line_nonempty;
        logic colon_seen;
    } t_line_flags;

    typedef struct packed {
        logic [SIZE_BITS-1:0] bytes_left;
        t_line_flags          flags;
    } t_line_state;

    // One result request as it leaves the decoder.
    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_valid;
        t_status    status;
    } t_result;

    // Returns {valid, value} of an ASCII hex digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0_0000;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== hdl/hcbd_core.sv =====
// ============================================================================
// hcbd_core
// Decoder state and the per-byte update; one byte is processed per fire.
// ============================================================================
module hcbd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output hcbd_pkg::t_result o_result
);

    hcbd_pkg::t_phase      r_phase,  n_phase;
    hcbd_pkg::t_status     r_status, n_status;
    hcbd_pkg::t_line_state r_line,   n_line;

    // Apply one ordinary line character to the line state.
    function automatic hcbd_pkg::t_line_state line_char(
        input hcbd_pkg::t_phase      ph,
        input hcbd_pkg::t_line_state s,
        input logic [7:0]            c
    );
        hcbd_pkg::t_line_state r;
        logic [4:0]            hv;
        r  = s;
        hv = hcbd_pkg::hex_decode(c);
        if (ph == hcbd_pkg::PH_SIZE) begin
            if (!s.flags.in_extension) begin
                if (c == hcbd_pkg::CH_SEMI) begin
                    r.flags.in_extension = 1'b1;
                end else if (c == hcbd_pkg::CH_SPACE || c == hcbd_pkg::CH_TAB) begin
                    if (s.flags.digit_seen) begin
                        r.flags.space_after_digits = 1'b1;
                    end
                end else if (!hv[4] || s.flags.space_after_digits) begin
                    r.flags.line_bad = 1'b1;
                end else begin
                    r.flags.digit_seen = 1'b1;
                    if (s.bytes_left[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'h0) begin
                        r.flags.line_bad = 1'b1;
                    end else begin
                        r.bytes_left = {s.bytes_left[hcbd_pkg::SIZE_BITS-5:0], hv[3:0]};
                    end
                end
            end
        end else begin
            r.flags.line_nonempty = 1'b1;
            if (c == hcbd_pkg::CH_COLON) begin
                r.flags.colon_seen = 1'b1;
            end
        end
        return r;
    endfunction

    // Next state.
    always_comb begin
        hcbd_pkg::t_line_state ls;
        logic                  eol;
        n_phase  = r_phase;
        n_status = r_status;
        n_line   = r_line;
        ls       = r_line;
        eol      = 1'b0;
        if (r_status == hcbd_pkg::ST_RUN) begin
            unique case (r_phase)
                hcbd_pkg::PH_SIZE, hcbd_pkg::PH_TRAIL: begin
                    if (ls.flags.cr_pending) begin
                        ls.flags.cr_pending = 1'b0;
                        if (i_byte == hcbd_pkg::CH_LF) begin
                            eol = 1'b1;
                        end else begin
                            ls = line_char(r_phase, ls, hcbd_pkg::CH_CR);
                        end
                    end
                    if (eol) begin
                        if (r_phase == hcbd_pkg::PH_SIZE) begin
                            if (!r_line.flags.digit_seen || r_line.flags.line_bad) begin
                                n_status = hcbd_pkg::ST_BADSIZE;
                            end else if (r_line.bytes_left == '0) begin
                                n_phase = hcbd_pkg::PH_TRAIL;
                            end else begin
                                n_phase = hcbd_pkg::PH_DATA;
                            end
                        end else begin
                            if (!r_line.flags.line_nonempty) begin
                                n_status = hcbd_pkg::ST_DONE;
                            end else if (!r_line.flags.colon_seen) begin
                                n_status = hcbd_pkg::ST_BADTRAIL;
                            end
                        end
                        n_line.flags = '0;
                    end else begin
                        if (i_byte == hcbd_pkg::CH_CR) begin
                            ls.flags.cr_pending = 1'b1;
                        end else begin
                            ls = line_char(r_phase, ls, i_byte);
                        end
                        n_line = ls;
                    end
                end
                hcbd_pkg::PH_DATA: begin
                    n_line.bytes_left = r_line.bytes_left
                                      - {{(hcbd_pkg::SIZE_BITS-1){1'b0}}, 1'b1};
                    if (n_line.bytes_left == '0) begin
                        n_phase = hcbd_pkg::PH_DCR;
                    end
                end
                hcbd_pkg::PH_DCR: begin
                    if (i_byte == hcbd_pkg::CH_CR) begin
                        n_phase = hcbd_pkg::PH_DLF;
                    end else begin
                        n_status = hcbd_pkg::ST_BADTERM;
                    end
                end
                hcbd_pkg::PH_DLF: begin
                    if (i_byte == hcbd_pkg::CH_LF) begin
                        n_phase = hcbd_pkg::PH_SIZE;
                        n_line  = '0;
                    end else begin
                        n_status = hcbd_pkg::ST_BADTERM;
                    end
                end
                default: begin
                    n_phase = hcbd_pkg::PH_SIZE;
                end
            endcase
        end
    end

    // Outputs: pass payload bytes, report status after this byte.
    always_comb begin
        o_result.body_byte  = 8'h00;
        o_result.body_valid = 1'b0;
        o_result.status     = n_status;
        if (r_status == hcbd_pkg::ST_RUN && r_phase == hcbd_pkg::PH_DATA) begin
            o_result.body_byte  = i_byte;
            o_result.body_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hcbd_pkg::PH_SIZE;
            r_status <= hcbd_pkg::ST_RUN;
            r_line   <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_line   <= n_line;
        end
    end

    // Status never changes once a final code is reached.
    a_status_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status != hcbd_pkg::ST_RUN |=> r_status == $past(r_status))
        else $error("status changed after finish");

    // Waiting for the chunk terminator implies the chunk was fully counted.
    a_term_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hcbd_pkg::PH_DCR || r_phase == hcbd_pkg::PH_DLF)
            |-> r_line.bytes_left == '0)
        else $error("terminator phase with bytes left");

    // A data phase always has bytes to pass.
    a_data_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == hcbd_pkg::PH_DATA |-> r_line.bytes_left != '0)
        else $error("data phase with empty count");

endmodule

// ===== hdl/hcbd_out_skid.sv =====
// ============================================================================
// hcbd_out_skid
// Two-entry result buffer: a main output register plus a skid register.
// ============================================================================
module hcbd_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hcbd_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output hcbd_pkg::t_result o_data
);

    logic              r_main_valid, n_main_valid;
    logic              r_skid_valid, n_skid_valid;
    hcbd_pkg::t_result r_main, n_main;
    hcbd_pkg::t_result r_skid, n_skid;
    logic              pop;

    assign pop     = r_main_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_comb begin
        n_main       = r_main;
        n_skid       = r_skid;
        n_main_valid = r_main_valid && !pop;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (pop) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    // The skid entry only fills behind a held main entry.
    a_skid_behind_main : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry without main entry");

    // A push into a full buffer would drop a result.
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("push into full buffer");

endmodule

// ===== hdl/http_chunked_body_decoder_top.sv =====
// ============================================================================
// http_chunked_body_decoder_top
// Streaming HTTP/1.1 chunked transfer body decoder, one byte per request.
// ============================================================================
// Usage:
//   s_axis carries the raw chunked body, one byte per request in tdata[7:0].
//   m_axis returns exactly one result request per input byte, in order:
//     tdata[7:0]  decoded body byte (zero when it is not payload)
//     tdata[10:8] status after this byte: 0 running, 1 complete,
//                 2 bad chunk size, 3 bad chunk terminator, 4 bad trailer
//     tuser       1 when this byte was chunk payload data
//   Status is sticky: after a final code every later byte is still answered,
//   with tuser 0 and the held status.
// Timing:
//   An accepted byte lands in an input register; when the result buffer has room
//   the decoder updates its state and writes the result into the output buffer,
//   which shows it on m_axis. One byte per cycle is sustained while m_axis takes
//   results; the decoder's state update on each fire sets that rate.
// Reset and stall:
//   Synchronous active-low reset returns to the first chunk size line with
//   status running and empties both registers. On an m_axis stall the skid
//   and input registers fill, then s_axis_tready drops until space.
// ============================================================================
module http_chunked_body_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] body_byte, [10:8] status, rest zero
    output logic        m_axis_tuser    // [0] body_valid
);

    // Input register stage.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic              buf_ready;
    logic              fire;
    hcbd_pkg::t_result result;
    hcbd_pkg::t_result out_data;

    // Process the held byte when the result buffer has room.
    assign fire          = r_in_valid && buf_ready;
    // Take a new byte whenever the input register is empty or drains now.
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    hcbd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    hcbd_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (result),
        .o_ready (buf_ready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_data)
    );

    assign m_axis_tdata = {5'b0_0000, out_data.status, out_data.body_byte};
    assign m_axis_tuser = out_data.body_valid;

    // Payload is only ever reported while the decoder is still running.
    a_payload_running : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[10:8] == hcbd_pkg::ST_RUN)
        else $error("payload byte with final status");

    // A non-payload result carries a zero data byte.
    a_zero_filler : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata[7:0] == 8'h00)
        else $error("non-payload result with data");

endmodule

// ===== tb/sv/tb_http_chunked_body_decoder_top.sv =====
// ============================================================================
// tb_http_chunked_body_decoder_top
// Self-checking bench for the streaming HTTP chunked body decoder.
// ============================================================================
// A short table of hand-picked bytes opens the run: blanks and leading zeros
// around the size, an extension that holds a lone CR, payload extremes and
// CR/LF inside the payload. A long stream of well-formed chunks with random
// sizes, extensions and payload follows. The run then closes the body in one
// of four ways picked at random: a clean finish through trailer lines, or a
// bad size, a bad chunk terminator or a bad trailer line. A few noise bytes
// after that check that the status holds. Every accepted byte runs through a
// local decoder model; each result request is compared against the oldest
// expected one. Both sides idle at random, except in one long quiet stretch.
// ============================================================================
module tb_http_chunked_body_decoder_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT  = 2000;  // cycles without any request
    localparam int unsigned BODY_TARGET = 1820;  // bytes of well-formed chunks

    // One row of the opening table; typed rows carry their result by hand.
    typedef struct packed {
        logic [7:0]        in_byte;
        logic              typed;
        logic [7:0]        exp_byte;
        logic              exp_valid;
        hcbd_pkg::t_status exp_status;
    } t_dir_row;

    // Size line " \t0A ;x<CR>:<CR><LF>" gives a 10 byte chunk; the CR inside
    // the extension is not followed by LF, so it stays an ordinary character.
    localparam t_dir_row DIRECTED_ROWS [23] = '{
        '{hcbd_pkg::CH_SPACE, 1'b1, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{hcbd_pkg::CH_TAB,   1'b1, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{"0",                1'b0, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{"A",                1'b0, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{hcbd_pkg::CH_SPACE, 1'b0, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{hcbd_pkg::CH_SEMI,  1'b1, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{"x",                1'b0, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{hcbd_pkg::CH_CR,    1'b1, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{hcbd_pkg::CH_COLON, 1'b0, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{hcbd_pkg::CH_CR,    1'b1, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{hcbd_pkg::CH_LF,    1'b1, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{8'h00,              1'b1, 8'h00, 1'b1, hcbd_pkg::ST_RUN},
        '{8'hFF,              1'b1, 8'hFF, 1'b1, hcbd_pkg::ST_RUN},
        '{hcbd_pkg::CH_CR,    1'b1, hcbd_pkg::CH_CR, 1'b1, hcbd_pkg::ST_RUN},
        '{hcbd_pkg::CH_LF,    1'b1, hcbd_pkg::CH_LF, 1'b1, hcbd_pkg::ST_RUN},
        '{8'h80,              1'b0, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{8'h7F,              1'b0, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{hcbd_pkg::CH_SEMI,  1'b0, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{hcbd_pkg::CH_COLON, 1'b0, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{8'h55,              1'b0, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{8'hAA,              1'b1, 8'hAA, 1'b1, hcbd_pkg::ST_RUN},
        '{hcbd_pkg::CH_CR,    1'b1, 8'h00, 1'b0, hcbd_pkg::ST_RUN},
        '{hcbd_pkg::CH_LF,    1'b1, 8'h00, 1'b0, hcbd_pkg::ST_RUN}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [7:0] body_byte, [10:8] status, rest zero
    logic        m_axis_tuser;    // [0] body_valid

    // Decoder model state.
    hcbd_pkg::t_phase               dec_phase;
    logic [hcbd_pkg::SIZE_BITS-1:0] chunk_left;
    hcbd_pkg::t_line_flags          line_f;
    hcbd_pkg::t_status              body_status;

    hcbd_pkg::t_result pending_results [$];   // results owed by the block, oldest first
    logic [7:0]        wire_bytes [$];        // random body, built before it is sent
    hcbd_pkg::t_result oldest_result;
    int unsigned       fail_count;
    bit                calm_stretch;          // both sides stop idling while set

    http_chunked_body_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------

    // Return 1 and the value when c is an ASCII hex digit of either case.
    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
        logic [7:0] folded;
        folded = c | 8'h20;
        v = 4'h0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
            return 1'b1;
        end
        if (folded >= "a" && folded <= "f") begin
            v = 4'(folded - "a" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Fold one ordinary character into the current size or trailer line.
    function automatic void take_line_char(input logic [7:0] c);
        logic [3:0] nib;
        if (dec_phase != hcbd_pkg::PH_SIZE) begin
            line_f.line_nonempty = 1'b1;
            if (c == hcbd_pkg::CH_COLON) line_f.colon_seen = 1'b1;
        end else if (!line_f.in_extension) begin
            if (c == hcbd_pkg::CH_SEMI) begin
                line_f.in_extension = 1'b1;
            end else if (c == hcbd_pkg::CH_SPACE || c == hcbd_pkg::CH_TAB) begin
                if (line_f.digit_seen) line_f.space_after_digits = 1'b1;
            end else if (!hex_nibble(c, nib) || line_f.space_after_digits) begin
                line_f.line_bad = 1'b1;
            end else begin
                line_f.digit_seen = 1'b1;
                // the next shift would push a set nibble out of the counter
                if (chunk_left[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'h0) line_f.line_bad = 1'b1;
                else chunk_left = {chunk_left[hcbd_pkg::SIZE_BITS-5:0], nib};
            end
        end
    endfunction

    // Advance the model by one byte and return the result it owes.
    function automatic hcbd_pkg::t_result decode_byte(input logic [7:0] c);
        hcbd_pkg::t_result r;
        logic              line_done;
        r = '{body_byte: 8'h00, body_valid: 1'b0, status: hcbd_pkg::ST_RUN};
        line_done = 1'b0;
        if (body_status == hcbd_pkg::ST_RUN) begin
            case (dec_phase)
                hcbd_pkg::PH_SIZE, hcbd_pkg::PH_TRAIL: begin
                    // a held CR either closes the line or turns into text
                    if (line_f.cr_pending) begin
                        line_f.cr_pending = 1'b0;
                        if (c == hcbd_pkg::CH_LF) line_done = 1'b1;
                        else take_line_char(hcbd_pkg::CH_CR);
                    end
                    if (line_done) begin
                        if (dec_phase == hcbd_pkg::PH_SIZE) begin
                            if (!line_f.digit_seen || line_f.line_bad)
                                body_status = hcbd_pkg::ST_BADSIZE;
                            else if (chunk_left == '0)
                                dec_phase = hcbd_pkg::PH_TRAIL;
                            else
                                dec_phase = hcbd_pkg::PH_DATA;
                        end else if (!line_f.line_nonempty) begin
                            body_status = hcbd_pkg::ST_DONE;
                        end else if (!line_f.colon_seen) begin
                            body_status = hcbd_pkg::ST_BADTRAIL;
                        end
                        line_f = '0;
                    end else if (c == hcbd_pkg::CH_CR) begin
                        line_f.cr_pending = 1'b1;
                    end else begin
                        take_line_char(c);
                    end
                end
                hcbd_pkg::PH_DATA: begin
                    r.body_byte  = c;
                    r.body_valid = 1'b1;
                    chunk_left   = chunk_left - {{(hcbd_pkg::SIZE_BITS-1){1'b0}}, 1'b1};
                    if (chunk_left == '0) dec_phase = hcbd_pkg::PH_DCR;
                end
                hcbd_pkg::PH_DCR: begin
                    if (c == hcbd_pkg::CH_CR) dec_phase = hcbd_pkg::PH_DLF;
                    else body_status = hcbd_pkg::ST_BADTERM;
                end
                hcbd_pkg::PH_DLF: begin
                    if (c == hcbd_pkg::CH_LF) begin
                        dec_phase  = hcbd_pkg::PH_SIZE;
                        chunk_left = '0;
                        line_f     = '0;
                    end else begin
                        body_status = hcbd_pkg::ST_BADTERM;
                    end
                end
                default: begin
                    dec_phase = hcbd_pkg::PH_SIZE;
                end
            endcase
        end
        r.status = body_status;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Body builders: append bytes to wire_bytes
    // ------------------------------------------------------------------------

    function automatic void append_wire(input logic [7:0] c);
        wire_bytes.insert(wire_bytes.size(), c);
    endfunction

    function automatic void push_blanks(input int unsigned most);
        repeat ($urandom_range(most))
            append_wire($urandom_range(1) ? hcbd_pkg::CH_SPACE : hcbd_pkg::CH_TAB);
    endfunction

    // Random line text with no CR LF pair in it; a CR is always trailed by a
    // plain character so it stays a lone CR.
    function automatic void push_line_text(input int unsigned n, input bit allow_colon);
        logic [7:0] c;
        repeat (n) begin
            c = 8'($urandom_range(255));
            if (c == hcbd_pkg::CH_LF) c = "-";
            if (!allow_colon && c == hcbd_pkg::CH_COLON) c = "=";
            append_wire(c);
            if (c == hcbd_pkg::CH_CR) append_wire(".");
        end
    endfunction

    function automatic void push_data(input int unsigned n);
        repeat (n) append_wire(8'($urandom_range(255)));
    endfunction

    function automatic void push_eol();
        append_wire(hcbd_pkg::CH_CR);
        append_wire(hcbd_pkg::CH_LF);
    endfunction

    // Size line with random blanks, leading zeros, digit case and extension.
    function automatic void push_size_line(input int unsigned size);
        int unsigned nibbles;
        logic [3:0]  v;
        nibbles = 1;
        while (nibbles < hcbd_pkg::SIZE_BITS / 4 && (size >> (4 * nibbles)) != 0) nibbles++;
        push_blanks(2);
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) append_wire("0");
        for (int k = int'(nibbles) - 1; k >= 0; k--) begin
            v = 4'(size >> (4 * k));
            if (v < 4'd10) append_wire(8'("0" + v));
            else append_wire(8'(($urandom_range(1) ? "A" : "a") + v - 8'd10));
        end
        push_blanks(2);
        if ($urandom_range(2) == 0) begin
            append_wire(hcbd_pkg::CH_SEMI);
            push_line_text($urandom_range(8), 1'b1);
        end
        push_eol();
    endfunction

    // Trailer line that holds at least one colon.
    function automatic void push_trailer();
        push_line_text($urandom_range(6), 1'b1);
        append_wire(hcbd_pkg::CH_COLON);
        push_line_text($urandom_range(6), 1'b1);
        push_eol();
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one byte, hold it until taken, then queue what it must produce.
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input hcbd_pkg::t_result typed_res);
        hcbd_pkg::t_result predicted;
        while (!calm_stretch && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = decode_byte(b);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    endtask

    initial begin : stimulus
        hcbd_pkg::t_result typed_res;
        t_dir_row          row;
        int unsigned       n;
        fail_count    = 0;
        calm_stretch  = 1'b0;
        dec_phase     = hcbd_pkg::PH_SIZE;
        chunk_left    = '0;
        line_f        = '0;
        body_status   = hcbd_pkg::ST_RUN;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the opening table.
        foreach (DIRECTED_ROWS[k]) begin
            row = DIRECTED_ROWS[k];
            typed_res = '{body_byte: row.exp_byte, body_valid: row.exp_valid,
                          status: row.exp_status};
            send_byte(row.in_byte, row.typed, typed_res);
        end

        // Hold off until the block has answered every byte so far.
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);

        // Well-formed chunks: mostly short, some medium, a few long.
        while (wire_bytes.size() < BODY_TARGET) begin
            case ($urandom_range(99)) inside
                [0:84]:  n = $urandom_range(1, 24);
                [85:97]: n = $urandom_range(25, 200);
                default: n = $urandom_range(256, 768);
            endcase
            push_size_line(n);
            push_data(n);
            push_eol();
        end

        // Close the body one of four ways.
        case ($urandom_range(3))
            0: begin
                // clean finish through zero or more trailers
                push_size_line(0);
                repeat ($urandom_range(3)) push_trailer();
                push_eol();
            end
            1: begin
                push_blanks(1);
                case ($urandom_range(6))
                    0: begin
                        // blank between digits
                        append_wire("1");
                        push_blanks(0);
                        append_wire($urandom_range(1) ? hcbd_pkg::CH_SPACE : hcbd_pkg::CH_TAB);
                        append_wire("2");
                    end
                    1: begin
                        // hex prefix
                        append_wire("0");
                        append_wire("x");
                        append_wire("1");
                    end
                    2: begin
                        // sign
                        append_wire($urandom_range(1) ? "+" : "-");
                        append_wire("5");
                    end
                    3: begin
                        // no digits before the end of line or the extension
                        if ($urandom_range(1)) begin
                            append_wire(hcbd_pkg::CH_SEMI);
                            push_line_text($urandom_range(4), 1'b1);
                        end
                    end
                    4: begin
                        // one nibble more than the counter holds
                        repeat ($urandom_range(2)) append_wire("0");
                        append_wire("1");
                        repeat (hcbd_pkg::SIZE_BITS / 4) append_wire("0");
                    end
                    5: begin
                        // lone CR among the digits
                        append_wire("1");
                        append_wire(hcbd_pkg::CH_CR);
                        append_wire("2");
                    end
                    default: begin
                        append_wire("g");
                    end
                endcase
                push_eol();
            end
            2: begin
                // chunk whose terminator breaks at the CR or at the LF
                n = $urandom_range(1, 6);
                push_size_line(n);
                push_data(n);
                if ($urandom_range(1)) begin
                    append_wire(hcbd_pkg::CH_CR);
                    append_wire($urandom_range(1) ? hcbd_pkg::CH_CR : 8'h00);
                end else begin
                    append_wire($urandom_range(1) ? hcbd_pkg::CH_LF : 8'hFF);
                end
            end
            default: begin
                // trailer line without a colon, or one holding only a lone CR
                push_size_line(0);
                repeat ($urandom_range(2)) push_trailer();
                if ($urandom_range(1)) append_wire(hcbd_pkg::CH_CR);
                else push_line_text($urandom_range(1, 8), 1'b0);
                push_eol();
            end
        endcase
        // Noise after the final status; every byte still gets a result.
        push_data(6);

        typed_res = '{body_byte: 8'h00, body_valid: 1'b0, status: hcbd_pkg::ST_RUN};
        foreach (wire_bytes[k]) begin
            calm_stretch = (k >= 600 && k < 1000);
            send_byte(wire_bytes[k], 1'b0, typed_res);
        end
        calm_stretch = 1'b0;
        s_axis_tvalid <= 1'b0;

        // Drain, then give the pipeline a few more cycles to misbehave.
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
        end
    endtask

    // Compare each result request with the oldest expectation, then pick
    // the ready level for the next cycle.
    initial begin : result_side
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $error("result request with none expected: tdata 0x%04h tuser %0b",
                           m_axis_tdata, m_axis_tuser);
                end else begin
                    oldest_result = pending_results.pop_front();
                    check_field("body_byte", oldest_result.body_byte, m_axis_tdata[7:0]);
                    check_field("body_valid", 8'(oldest_result.body_valid), 8'(m_axis_tuser));
                    check_field("status", 8'(oldest_result.status), 8'(m_axis_tdata[10:8]));
                    check_field("tdata padding", 8'h00, 8'(m_axis_tdata[15:11]));
                end
            end
            m_axis_tready <= calm_stretch || ($urandom_range(99) >= 7);
        end
    end

    // End the run when neither side has moved a request for too long.
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== http_chunked_body_decoder_top.f =====
hdl/hcbd_pkg.sv
hdl/hcbd_core.sv
hdl/hcbd_out_skid.sv
hdl/http_chunked_body_decoder_top.sv
tb/sv/tb_http_chunked_body_decoder_top.sv
